### design/ptes_pkg.sv
// Package for the periodic timer event scheduler: sizes, operation codes and
// the command and status bundles between controller and datapath.
// No dependencies.
package ptes_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 48;
  localparam int PER_W      = 32;
  localparam int ID_W       = 4;
  localparam int OP_W       = 2;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(TIME_BITS);
  localparam int IN_DATA_W  = ((ID_W + PER_W + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_STOP = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef struct packed {
    logic             load_now;
    logic             do_set;
    logic             do_stop;
    logic             scan_init;
    logic             scan_step;
    logic             scan_first;
    logic [IDX_W-1:0] idx;
    logic             mod_start;
    logic             mod_step;
    logic             base_step;
    logic             due_write;
    logic             oneshot_clear;
    logic             out_fire;
    logic             out_empty;
  } ptes_cmd_t;

  typedef struct packed {
    logic found;
    logic per_zero;
    logic more;
    logic out_free;
  } ptes_stat_t;

endpackage

### design/ptes_dp.sv
// Datapath of the timer scheduler: slot tables, scan best-pick registers,
// bit-serial remainder unit for due-time catch-up and the result register.
// Depends on ptes_pkg.
module ptes_dp import ptes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptes_cmd_t            cmd,
  output ptes_stat_t           stat,
  input  logic [ID_W-1:0]      in_id,
  input  logic [PER_W-1:0]     in_period,
  input  logic [TIME_BITS-1:0] in_now,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_fired,
  output logic [ID_W-1:0]      out_id,
  output logic                 out_last
);

  logic [TIME_BITS-1:0]  due_mem [NUM_TIMERS];
  logic [PER_W-1:0]      per_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] reg_r;
  logic [NUM_TIMERS-1:0] pending_r;

  logic [TIME_BITS-1:0] now_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_BITS-1:0] best_due_r;
  logic [PER_W-1:0]     best_per_r;

  logic [TIME_BITS-1:0] diff_r;
  logic [PER_W:0]       mod_rem_r;
  logic [TIME_BITS-1:0] base_r;

  logic                 out_valid_r;
  logic                 out_fired_r;
  logic [ID_W-1:0]      out_id_r;
  logic                 out_last_r;

  logic                  slot_ok;
  logic [IDX_W-1:0]      set_idx;
  logic [TIME_BITS:0]    set_sum;
  logic [TIME_BITS-1:0]  set_due;
  logic [TIME_BITS-1:0]  rd_due;
  logic                  eligible;
  logic                  better;
  logic [PER_W:0]        rem_sh;
  logic [PER_W:0]        rem_nxt;
  logic [TIME_BITS:0]    upd_sum;
  logic [TIME_BITS-1:0]  upd_due;
  logic [NUM_TIMERS-1:0] best_hot;
  logic                  out_free;

  assign slot_ok = int'(in_id) < NUM_TIMERS;
  assign set_idx = IDX_W'(in_id);
  assign set_sum = {1'b0, in_now} + (TIME_BITS+1)'(in_period);
  assign set_due = set_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : set_sum[TIME_BITS-1:0];

  // First pass builds the pending set; later passes only look at it
  assign rd_due   = due_mem[cmd.idx];
  assign eligible = cmd.scan_first ? (reg_r[cmd.idx] && (rd_due <= now_r))
                                   : pending_r[cmd.idx];
  assign better   = !found_r || (rd_due < best_due_r);

  // Restoring remainder, one dividend bit per step
  assign rem_sh  = {mod_rem_r[PER_W-1:0], diff_r[TIME_BITS-1]};
  assign rem_nxt = (rem_sh >= {1'b0, best_per_r}) ? rem_sh - {1'b0, best_per_r} : rem_sh;

  assign upd_sum = {1'b0, base_r} + (TIME_BITS+1)'(best_per_r);
  assign upd_due = upd_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : upd_sum[TIME_BITS-1:0];

  assign best_hot = NUM_TIMERS'(1) << best_idx_r;
  assign out_free = !out_valid_r || out_ready;

  assign stat.found    = found_r;
  assign stat.per_zero = (best_per_r == '0);
  assign stat.more     = |(pending_r & ~best_hot);
  assign stat.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_fired = out_fired_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_set && slot_ok) begin
        reg_r[set_idx] <= 1'b1;
      end
      if (cmd.do_stop && slot_ok) begin
        reg_r[set_idx] <= 1'b0;
      end
      if (cmd.oneshot_clear) begin
        reg_r[best_idx_r] <= 1'b0;
      end
      if (cmd.scan_init) begin
        found_r <= 1'b0;
      end else if (cmd.scan_step && eligible) begin
        found_r <= 1'b1;
      end
      if (cmd.out_fire || cmd.out_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_set && slot_ok) begin
      per_mem[set_idx] <= in_period;
      due_mem[set_idx] <= set_due;
    end
    if (cmd.due_write) begin
      due_mem[best_idx_r] <= upd_due;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      now_r <= in_now;
    end
    if (cmd.scan_step) begin
      if (cmd.scan_first) begin
        pending_r[cmd.idx] <= eligible;
      end
      if (eligible && better) begin
        best_idx_r <= cmd.idx;
        best_due_r <= rd_due;
        best_per_r <= per_mem[cmd.idx];
      end
    end
    if (cmd.out_fire) begin
      pending_r[best_idx_r] <= 1'b0;
    end
    if (cmd.mod_start) begin
      diff_r    <= now_r - best_due_r;
      mod_rem_r <= '0;
    end else if (cmd.mod_step) begin
      diff_r    <= {diff_r[TIME_BITS-2:0], 1'b0};
      mod_rem_r <= rem_nxt;
    end
    if (cmd.base_step) begin
      base_r <= now_r - TIME_BITS'(mod_rem_r[PER_W-1:0]);
    end
    if (cmd.out_fire) begin
      out_fired_r <= 1'b1;
      out_id_r    <= ID_W'(best_idx_r);
      out_last_r  <= !stat.more;
    end else if (cmd.out_empty) begin
      out_fired_r <= 1'b0;
      out_id_r    <= '0;
      out_last_r  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.base_step |-> (mod_rem_r < {1'b0, best_per_r}))
    else $error("remainder not below period");

  a_new_due_past_now: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.due_write |-> ((upd_due > now_r) || (upd_due == {TIME_BITS{1'b1}})))
    else $error("catch-up due time not past now");

  a_fire_was_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fire |-> (found_r && pending_r[best_idx_r]))
    else $error("fired slot was not pending");
`endif

endmodule

### design/ptes_ctrl.sv
// Controller of the timer scheduler: sequences the slot scan, catch-up
// remainder steps and result hand-off. Depends on ptes_pkg.
module ptes_ctrl import ptes_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  ptes_stat_t      stat,
  output ptes_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOD,
    S_BASE,
    S_UPD,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  logic             first_r, first_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    first_nxt = first_r;
    cmd       = '0;
    cmd.idx        = idx_r;
    cmd.scan_first = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_SET:  cmd.do_set = 1'b1;
            OP_STOP: cmd.do_stop = 1'b1;
            OP_TICK: begin
              cmd.load_now  = 1'b1;
              cmd.scan_init = 1'b1;
              idx_nxt       = '0;
              first_nxt     = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == IDX_W'(NUM_TIMERS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.found) begin
          state_nxt = S_EMPTY;
        end else if (stat.per_zero) begin
          cmd.oneshot_clear = 1'b1;
          state_nxt         = S_EMIT;
        end else begin
          cmd.mod_start = 1'b1;
          bit_nxt       = '0;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        bit_nxt      = bit_r + 1'b1;
        if (bit_r == CNT_W'(TIME_BITS - 1)) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd.base_step = 1'b1;
        state_nxt     = S_UPD;
      end
      S_UPD: begin
        cmd.due_write = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_fire = 1'b1;
          first_nxt    = 1'b0;
          if (stat.more) begin
            cmd.scan_init = 1'b1;
            idx_nxt       = '0;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.out_empty = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      bit_r   <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bit_r   <= bit_nxt;
      first_r <= first_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_fire || cmd.out_empty) |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_empty_only_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_empty |-> first_r)
    else $error("empty result after a fired result");
`endif

endmodule

### design/periodic_timer_event_scheduler_unit.sv
// Periodic timer event scheduler, top level: stream ports around the
// controller and datapath. Depends on ptes_pkg, ptes_ctrl and ptes_dp.
//
// Keeps 16 timer slots. A set or stop transaction gives no result. A tick
// scans all slots one per cycle and fires the pending slots one per pass,
// earliest due time first (ties lowest slot), or gives one empty result when
// none is due. Each pass scans the slots, then decides and loads the result;
// a periodic slot adds 48 steps of the remainder unit, then forms the base
// time and writes the due time that catches up past now. Output stalls hold
// the emit. Results leave through a one-deep output register; input is taken
// only between ticks.
module periodic_timer_event_scheduler_unit import ptes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // timer_id, period, now, zero pad
  input  logic [OP_W-1:0]       in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // fired_id, zero pad
  output logic [0:0]            out_tuser,  // fired
  output logic                  out_tlast
);

  ptes_cmd_t            cmd;
  ptes_stat_t           stat;
  logic [ID_W-1:0]      in_id;
  logic [PER_W-1:0]     in_period;
  logic [TIME_BITS-1:0] in_now;
  logic                 out_fired;
  logic [ID_W-1:0]      out_id;

  assign in_id     = in_tdata[ID_W-1:0];
  assign in_period = in_tdata[ID_W +: PER_W];
  assign in_now    = in_tdata[ID_W+PER_W +: TIME_BITS];

  ptes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptes_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_id     (in_id),
    .in_period (in_period),
    .in_now    (in_now),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_fired (out_fired),
    .out_id    (out_id),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'(out_id);
  assign out_tuser = out_fired;

endmodule

### tb/tb_periodic_timer_event_scheduler_unit.sv
// Testbench for periodic_timer_event_scheduler_unit: directed table then random set, stop,
// tick and unused-op transactions, results checked against typed rows or a bench scheduler.
// Depends on ptes_pkg and the scheduler RTL.
module tb_periodic_timer_event_scheduler_unit;
  import ptes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 250;
  localparam int HOLD_AT     = N_DIRECTED + 80;
  localparam int HOLD_CYCLES = 500;
  localparam int PAUSE_AT    = N_DIRECTED + 180;
  localparam int IDLE_LIMIT  = 6000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last;
  } slot_event_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [PER_W-1:0]     per;
    logic [TIME_BITS-1:0] now;
    logic                 typed;
    slot_event_t          want;
  } stim_row_t;

  localparam slot_event_t EMPTY_TICK = '{1'b0, 4'd0, 1'b1};
  localparam slot_event_t NO_CHECK   = '0;

  // Rows marked typed carry their only result; the rest go through the predictor.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_TICK,   4'd0,  32'd0,          48'd0,               1'b1, EMPTY_TICK},
    '{OP_SET,    4'd0,  32'd0,          48'd0,               1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd0,               1'b1, '{1'b1, 4'd0, 1'b1}},
    '{OP_TICK,   4'd0,  32'd0,          48'd5,               1'b1, EMPTY_TICK},
    '{OP_SET,    4'd15, 32'hFFFF_FFFF,  48'd10,              1'b0, NO_CHECK},
    '{OP_SET,    4'd3,  32'd10,         48'd10,              1'b0, NO_CHECK},
    '{OP_SET,    4'd7,  32'd10,         48'd5,               1'b0, NO_CHECK},
    '{OP_SET,    4'd9,  32'd5,          48'd10,              1'b0, NO_CHECK},
    '{OP_UNUSED, 4'd3,  32'd1,          48'd0,               1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd40,              1'b0, NO_CHECK},
    '{OP_STOP,   4'd9,  32'd0,          48'd40,              1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd60,              1'b0, NO_CHECK},
    '{OP_STOP,   4'd3,  32'd0,          48'd60,              1'b0, NO_CHECK},
    '{OP_STOP,   4'd7,  32'd0,          48'd60,              1'b0, NO_CHECK},
    '{OP_SET,    4'd5,  32'd1,          48'hFFFF_FFFF_FFF0,  1'b0, NO_CHECK},
    '{OP_SET,    4'd6,  32'd10,         48'hFFFF_FFFF_FFFF,  1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'hFFFF_FFFF_FFFF,  1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'hFFFF_FFFF_FFFF,  1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd100,             1'b0, NO_CHECK},
    '{OP_STOP,   4'd5,  32'd0,          48'd100,             1'b0, NO_CHECK},
    '{OP_STOP,   4'd6,  32'd0,          48'd100,             1'b0, NO_CHECK},
    '{OP_STOP,   4'd15, 32'd0,          48'd100,             1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd200,             1'b1, EMPTY_TICK},
    '{OP_SET,    4'd12, 32'd0,          48'd300,             1'b0, NO_CHECK},
    '{OP_TICK,   4'd0,  32'd0,          48'd299,             1'b1, EMPTY_TICK}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // timer_id, period, now, zero pad
  logic [OP_W-1:0]       in_tuser = '0;   // op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // fired_id, zero pad
  logic [0:0]            out_tuser;       // fired
  logic                  out_tlast;

  periodic_timer_event_scheduler_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scheduler state mirrored in the bench
  logic                 slot_armed  [NUM_TIMERS];
  logic [TIME_BITS-1:0] slot_due    [NUM_TIMERS];
  logic [PER_W-1:0]     slot_period [NUM_TIMERS];

  slot_event_t          expected_fires [$];
  int                   err_count = 0;
  int                   items_accepted = 0;
  logic [TIME_BITS-1:0] cur_us = '0;

  function automatic logic [TIME_BITS-1:0] add_sat(logic [TIME_BITS-1:0] a,
                                                    logic [PER_W-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + (TIME_BITS+1)'(b);
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

  // Advance by whole periods until the due time lies past now.
  function automatic logic [TIME_BITS-1:0] catch_up_due(logic [TIME_BITS-1:0] due,
                                                         logic [PER_W-1:0] per,
                                                         logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] lag;
    if (due > now) return due;
    lag = now - due;
    return add_sat(now - (lag % TIME_BITS'(per)), per);
  endfunction

  function automatic void schedule_step(stim_row_t row, bit record);
    logic        pending [NUM_TIMERS];
    int          best;
    bit          found;
    slot_event_t fires [$];
    slot_event_t ev;
    case (row.op)
      OP_SET: begin
        slot_period[row.id] = row.per;
        slot_due[row.id]    = add_sat(row.now, row.per);
        slot_armed[row.id]  = 1'b1;
      end
      OP_STOP: begin
        slot_armed[row.id] = 1'b0;
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++)
          pending[i] = slot_armed[i] && (slot_due[i] <= row.now);
        do begin
          found = 1'b0;
          best  = 0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (pending[i] && (!found || slot_due[i] < slot_due[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            pending[best] = 1'b0;
            if (slot_period[best] != '0)
              slot_due[best] = catch_up_due(slot_due[best], slot_period[best], row.now);
            else
              slot_armed[best] = 1'b0;
            ev = '{1'b1, best[ID_W-1:0], 1'b0};
            fires.push_back(ev);
          end
        end while (found);
        if (fires.size() == 0)
          fires.push_back(EMPTY_TICK);
        else
          fires[fires.size()-1].last = 1'b1;
        if (record)
          foreach (fires[k]) expected_fires.push_back(fires[k]);
      end
      default: ;
    endcase
  endfunction

  // Mostly forward-moving time with small periods; now and then large jumps,
  // time going backwards, ticks at the top of the range and huge periods.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    int        step;
    row  = '0;
    pick = $urandom_range(0, 99);
    if (pick < 38)      row.op = OP_SET;
    else if (pick < 52) row.op = OP_STOP;
    else if (pick < 96) row.op = OP_TICK;
    else                row.op = OP_UNUSED;
    row.id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10)      row.per = '0;
    else if (pick < 16) row.per = PER_W'($urandom);
    else if (pick < 20) row.per = PER_W'(32'hFFFF_FFFF - $urandom_range(0, 3));
    else                row.per = PER_W'($urandom_range(1, 60));
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      step = $urandom_range(0, 40);
      row.now = (cur_us > TIME_MAX - 40) ? TIME_MAX : cur_us + TIME_BITS'(step);
    end else if (pick < 89) begin
      row.now = TIME_BITS'({$urandom, $urandom});
    end else if (pick < 95) begin
      step = $urandom_range(0, 30);
      row.now = (cur_us < 30) ? '0 : cur_us - TIME_BITS'(step);
    end else begin
      row.now = TIME_MAX - TIME_BITS'($urandom_range(0, 3));
    end
    cur_us = row.now;
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t row;
    int        burst_left;
    int        gap;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      slot_armed[i]  = 1'b0;
      slot_due[i]    = '0;
      slot_period[i] = '0;
    end
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    cur_us = 48'd300;
    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      row = (i < N_DIRECTED) ? DIRECTED[i] : random_row();
      gap = 0;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(1, 12);
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      end
      burst_left--;
      if (i == PAUSE_AT && gap == 0) gap = 1;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        // hold off until every outstanding tick result has drained
        if (i == PAUSE_AT)
          while (expected_fires.size() != 0) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= IN_DATA_W'({row.now, row.per, row.id});
      in_tuser  <= row.op;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      items_accepted++;
      if (row.typed) begin
        expected_fires.push_back(row.want);
        schedule_step(row, 1'b0);
      end else begin
        schedule_step(row, 1'b1);
      end
    end
    in_tvalid <= 1'b0;
    while (expected_fires.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Receiver: a 16-bit ready pattern, all ones or random, cycled through, plus one long hold.
  initial begin : result_sink
    logic [15:0] ready_pattern;
    int          phase;
    bit          long_hold_done;
    ready_pattern  = '1;
    phase          = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && items_accepted >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (phase % 64 == 0)
          ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        out_tready <= ready_pattern[phase % 16];
        phase++;
      end
    end
  end

  always @(posedge clk) begin : result_check
    slot_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_fires.size() == 0) begin
        $error("unexpected transaction: fired=%0b fired_id=%0d last=%0b",
               out_tuser[0], out_tdata[ID_W-1:0], out_tlast);
        err_count++;
      end else begin
        want = expected_fires.pop_front();
        if (out_tuser[0] !== want.fired) begin
          $error("fired: expected %0b, got %0b", want.fired, out_tuser[0]);
          err_count++;
        end
        if (out_tdata[ID_W-1:0] !== want.fired_id) begin
          $error("fired_id: expected %0d, got %0d", want.fired_id, out_tdata[ID_W-1:0]);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
